/* hdl/dtc_pkg.sv */
// ----------------------------------------------------------------------------
// dtc_pkg: shared types, widths and helpers for the domino tiling counter
// Field widths of the query and result channels, the largest supported mask
// width and the column-mask validity check used by the profile count.
// ----------------------------------------------------------------------------
package dtc_pkg;

   localparam int ROWS_W           = 4;
   localparam int COLS_W           = 7;
   localparam int COUNT_W          = 64;
   localparam int MASK_MAX_W       = 12;
   localparam int MAX_ROWS_DEFAULT = 11;

   typedef logic [MASK_MAX_W-1:0] mask_max_type;
   typedef logic [ROWS_W-1:0]     rows_type;
   typedef logic [COUNT_W-1:0]    count_type;

   // true when every run of zeros within the low nbits has even length
   function automatic logic mask_ok(mask_max_type mask, rows_type nbits);
      logic bad;
      logic odd;
      bad = 1'b0;
      odd = 1'b0;
      for (int b = 0; b < MASK_MAX_W; b++) begin
         if (rows_type'(b) < nbits) begin
            if (mask[b]) begin
               bad = bad | odd;
               odd = 1'b0;
            end else begin
               odd = ~odd;
            end
         end
      end
      return ~(bad | odd);
   endfunction

endpackage

/* hdl/domino_tiling_counter.sv */
// ----------------------------------------------------------------------------
// domino_tiling_counter: domino tiling count of a rows x cols grid
// A query (req_rows, req_cols) gives one result rsp_tilings, the number of
// ways to tile the grid with 1x2 dominoes, modulo 2^64. Both channels are
// valid/ready; a transfer happens when valid and ready are high together.
// The count is a column profile dynamic program kept in one synchronous
// memory split into two banks of 2^MAX_ROWS 64-bit counts (old column and
// new column). Each cycle one (new mask j, old mask k) pair with j AND k
// zero is read from the old bank and accumulated; the sum for j is written
// to the new bank after its last k. The single memory read port sets the
// rate. Each column reads every disjoint (j, k) pair in turn and then
// passes a drain state; after the last column, the done state loads the
// result register once it is free and returns to idle. Rows above
// MAX_ROWS are taken as MAX_ROWS. One query is in work at a time; req_ready
// is high only while the block is idle. The result sits in an output
// register; if the receiver stalls, the next query can be accepted and run,
// and its result waits until the previous one has been taken. No memory
// clearing is needed: the first column uses the known start counts and
// every entry read later was written in the column before. Reset returns
// the controller to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module domino_tiling_counter #(
   parameter int MAX_ROWS = dtc_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [dtc_pkg::ROWS_W-1:0] req_rows,
   input  logic [dtc_pkg::COLS_W-1:0] req_cols,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [dtc_pkg::COUNT_W-1:0] rsp_tilings
);

   localparam int MASK_W = MAX_ROWS;
   localparam int DEPTH  = 1 << MASK_W;
   localparam logic [dtc_pkg::ROWS_W-1:0] MaxRowsCode = dtc_pkg::ROWS_W'(MAX_ROWS);

   typedef enum logic [1:0] {
      IDLE,
      RUN,
      DRAIN,
      DONE
   } state_type;

   state_type                    state_ff;
   logic [dtc_pkg::ROWS_W-1:0]   rows_ff;
   logic [MASK_W-1:0]            full_ff;
   logic [dtc_pkg::COLS_W-1:0]   cols_left_ff;
   logic [MASK_W-1:0]            j_ff;
   logic [MASK_W-1:0]            k_ff;
   logic                         first_ff;
   logic                         first_col_ff;
   logic                         bank_ff;
   logic                         rsp_valid_ff;
   logic [dtc_pkg::COUNT_W-1:0]  rsp_tilings_ff;

   // read stage results
   logic                         s1_valid_ff;
   logic                         s1_first_ff;
   logic                         s1_last_ff;
   logic                         s1_kzero_ff;
   logic                         s1_ok_ff;
   logic [MASK_W-1:0]            s1_j_ff;
   logic [dtc_pkg::COUNT_W-1:0]  rd_data_ff;
   logic [dtc_pkg::COUNT_W-1:0]  acc_ff;
   logic [dtc_pkg::COUNT_W-1:0]  answer_ff;

   logic [dtc_pkg::COUNT_W-1:0]  count_mem [2*DEPTH];

   logic [dtc_pkg::ROWS_W-1:0]   rows_sat;
   logic [MASK_W-1:0]            full_req;
   logic [MASK_W-1:0]            comp;
   logic [MASK_W-1:0]            j_inc;
   logic                         k_last;
   logic                         j_last;
   logic [MASK_W:0]              rd_addr;
   logic [MASK_W:0]              wr_addr;
   logic [dtc_pkg::COUNT_W-1:0]  addend;
   logic [dtc_pkg::COUNT_W-1:0]  acc_in;
   logic                         pair_ok;

   assign rows_sat = (req_rows > MaxRowsCode) ? MaxRowsCode : req_rows;

   always_comb begin
      for (int b = 0; b < MASK_W; b++) begin
         full_req[b] = (dtc_pkg::ROWS_W'(b) < rows_sat);
      end
   end

   assign comp    = full_ff & ~j_ff;
   assign j_inc   = j_ff + MASK_W'(1);
   assign k_last  = (k_ff == '0);
   assign j_last  = (j_ff == full_ff);
   assign rd_addr = {bank_ff, k_ff};
   assign wr_addr = {~bank_ff, s1_j_ff};
   assign pair_ok = dtc_pkg::mask_ok(dtc_pkg::mask_max_type'(j_ff | k_ff), rows_ff);

   // first column: old counts are one at mask zero and zero elsewhere
   always_comb begin
      if (!s1_ok_ff) begin
         addend = '0;
      end else if (first_col_ff) begin
         addend = dtc_pkg::COUNT_W'(s1_kzero_ff);
      end else begin
         addend = rd_data_ff;
      end
      acc_in = (s1_first_ff ? '0 : acc_ff) + addend;
   end

   assign req_ready   = (state_ff == IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tilings = rsp_tilings_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= (state_ff == RUN);
         // in done a taken result is replaced by the new one below
         if (rsp_valid_ff && rsp_ready && state_ff != DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  rows_ff      <= rows_sat;
                  full_ff      <= full_req;
                  cols_left_ff <= req_cols;
                  j_ff         <= '0;
                  k_ff         <= full_req;
                  first_ff     <= 1'b1;
                  first_col_ff <= 1'b1;
                  bank_ff      <= 1'b0;
                  state_ff     <= (req_cols == '0) ? DONE : RUN;
               end
            end
            RUN: begin
               if (k_last) begin
                  if (j_last) begin
                     state_ff <= DRAIN;
                  end else begin
                     j_ff     <= j_inc;
                     k_ff     <= full_ff & ~j_inc;
                     first_ff <= 1'b1;
                  end
               end else begin
                  k_ff     <= (k_ff - MASK_W'(1)) & comp;
                  first_ff <= 1'b0;
               end
            end
            DRAIN: begin
               // last sum of the column lands this cycle, then the banks swap
               cols_left_ff <= cols_left_ff - dtc_pkg::COLS_W'(1);
               if (cols_left_ff == dtc_pkg::COLS_W'(1)) begin
                  state_ff <= DONE;
               end else begin
                  bank_ff      <= ~bank_ff;
                  first_col_ff <= 1'b0;
                  j_ff         <= '0;
                  k_ff         <= full_ff;
                  first_ff     <= 1'b1;
                  state_ff     <= RUN;
               end
            end
            DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_tilings_ff <= answer_ff;
                  state_ff       <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff  <= count_mem[rd_addr];
      s1_first_ff <= first_ff;
      s1_last_ff  <= k_last;
      s1_kzero_ff <= k_last;
      s1_ok_ff    <= pair_ok;
      s1_j_ff     <= j_ff;
      acc_ff      <= acc_in;
      if (s1_valid_ff && s1_last_ff) begin
         count_mem[wr_addr] <= acc_in;
      end
      if (state_ff == IDLE && req_valid) begin
         answer_ff <= dtc_pkg::COUNT_W'(1);
      end else if (s1_valid_ff && s1_last_ff && s1_j_ff == '0) begin
         answer_ff <= acc_in;
      end
   end

   // k is always a subset of the complement of j
   a_k_disjoint: assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |-> (k_ff & j_ff) == '0)
      else $error("old mask overlaps new mask");

   a_j_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |-> (j_ff & ~full_ff) == '0)
      else $error("new mask beyond row count");

   // the final write of a column falls in the drain cycle
   a_drain_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == DRAIN |-> s1_valid_ff && s1_last_ff && j_ff == full_ff)
      else $error("column end without its last write");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !s1_valid_ff || $past(state_ff == RUN))
      else $error("read stage busy while idle");

   a_done_from: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == DONE) |-> $past(state_ff == DRAIN) || $past(state_ff == IDLE))
      else $error("unexpected entry to done");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the domino tiling counter
// Queries of grid height and width go in through a queued driver. A local
// profile count predicts the number of tilings for each accepted query, and
// a monitor compares every returned count with the oldest prediction. The
// run sweeps the size extremes first, then random queries kept mostly small,
// under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_H      = dtc_pkg::MAX_ROWS_DEFAULT;
   localparam int RAND_ITEMS = 81;

   typedef logic [dtc_pkg::COLS_W-1:0] cols_type;

   typedef struct packed {
      dtc_pkg::rows_type rows;
      cols_type          cols;
   } query_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   dtc_pkg::rows_type  req_rows  = '0;
   cols_type           req_cols  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   dtc_pkg::count_type rsp_tilings;

   query_type          pending_queries[$];
   dtc_pkg::count_type tilings_due[$];
   int                 mismatches    = 0;
   int                 send_idle_pct = 7;
   int                 recv_idle_pct = 62;

   domino_tiling_counter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rows    (req_rows),
      .req_cols    (req_cols),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tilings (rsp_tilings)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // column is fillable by vertical dominoes when each gap of free cells is even
   function automatic logic free_runs_even(int unsigned profile, int unsigned height);
      int unsigned run;
      run = 0;
      for (int b = 0; b < height; b++) begin
         if ((profile >> b) & 1) begin
            if (run & 1)
               return 1'b0;
            run = 0;
         end else begin
            run++;
         end
      end
      return (run & 1) == 0;
   endfunction

   function automatic dtc_pkg::count_type count_tilings(dtc_pkg::rows_type rows,
                                                        cols_type cols);
      dtc_pkg::count_type cur [0:2047];
      dtc_pkg::count_type nxt [0:2047];
      logic               ok [0:2047];
      int unsigned        height;
      int unsigned        nprof;
      int unsigned        comp;
      int unsigned        k;
      dtc_pkg::count_type acc;
      height = (rows > MAX_H) ? MAX_H : rows;
      nprof  = 1 << height;
      for (int j = 0; j < nprof; j++) begin
         ok[j]  = free_runs_even(j, height);
         cur[j] = '0;
      end
      cur[0] = 1;
      for (int c = 0; c < cols; c++) begin
         for (int j = 0; j < nprof; j++) begin
            // walk every old profile disjoint from the new one
            comp = (nprof - 1) & ~j;
            k    = comp;
            acc  = '0;
            while (1) begin
               if (ok[j | k])
                  acc += cur[k];
               if (k == 0)
                  break;
               k = (k - 1) & comp;
            end
            nxt[j] = acc;
         end
         for (int j = 0; j < nprof; j++)
            cur[j] = nxt[j];
      end
      return cur[0];
   endfunction

   // mostly cheap sizes; the cost grows with 3^rows per column
   function automatic query_type random_query();
      query_type q;
      int        pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         q.rows = dtc_pkg::rows_type'($urandom_range(4));
         q.cols = cols_type'($urandom_range(127));
      end else if (pick < 90) begin
         q.rows = dtc_pkg::rows_type'($urandom_range(8, 5));
         q.cols = cols_type'($urandom_range(5));
      end else if (pick < 94) begin
         q.rows = dtc_pkg::rows_type'($urandom_range(10, 9));
         q.cols = cols_type'($urandom_range(1));
      end else begin
         q.rows = dtc_pkg::rows_type'($urandom_range(15, 11));
         q.cols = '0;
      end
      return q;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            tilings_due = {tilings_due, count_tilings(req_rows, req_cols)};
         if (!req_valid || req_ready) begin
            if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_rows  <= pending_queries[0].rows;
               req_cols  <= pending_queries[0].cols;
               void'(pending_queries.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      dtc_pkg::count_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tilings_due.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual tilings %0d",
                        $time, rsp_tilings);
               mismatches++;
            end else begin
               want = tilings_due.pop_front();
               if (rsp_tilings !== want) begin
                  $display("%0t: tilings mismatch, expected %0d, actual %0d",
                           $time, want, rsp_tilings);
                  mismatches++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic add_query(int rows, int cols);
      query_type q;
      q.rows = dtc_pkg::rows_type'(rows);
      q.cols = cols_type'(cols);
      pending_queries = {pending_queries, q};
   endtask

   // hold the sender back until every prediction has been matched
   task automatic drain();
      @(negedge clock);
      while (pending_queries.size() != 0 || req_valid || tilings_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // size extremes, empty grids, odd areas, wrapping counts and saturation
      add_query(0, 0);
      add_query(0, 1);
      add_query(0, 127);
      add_query(1, 0);
      add_query(1, 1);
      add_query(1, 2);
      add_query(2, 1);
      add_query(2, 2);
      add_query(2, 3);
      add_query(3, 2);
      add_query(4, 4);
      add_query(2, 127);
      add_query(3, 127);
      add_query(4, 127);
      add_query(6, 6);
      add_query(8, 8);
      add_query(9, 2);
      add_query(11, 2);
      add_query(12, 1);
      add_query(15, 0);
      add_query(15, 127 & 0);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               recv_idle_pct = 62;
            end
            1: begin
               send_idle_pct = 62;
               recv_idle_pct = 7;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int i = 0; i < RAND_ITEMS / 3; i++)
            pending_queries = {pending_queries, random_query()};
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #600_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
